/* sv/multichannel_occupancy_hold_reporter_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the occupancy hold reporter checker
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_OCCUPANCY_HOLD_REPORTER_UNIT_MACROS_SVH
`define MULTICHANNEL_OCCUPANCY_HOLD_REPORTER_UNIT_MACROS_SVH

// assertion sampled on clk_i, off while rst_ni is low
`define MOHR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mohr assertion failed");

// assertion sampled on clk_i, active during reset too
`define MOHR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mohr assertion failed");

`endif

/* sv/mohr_pkg.sv */
// ---------------------------------------------------------------------------
// mohr_pkg
// Shared types and constants of the occupancy hold reporter.
// ---------------------------------------------------------------------------
`default_nettype none
package mohr_pkg;

  localparam int Channels  = 8;
  localparam int ThreshDiv = 7;
  localparam logic [15:0] ReadFail = 16'hFFFF;

  typedef logic [2:0] chan_t;

  typedef enum logic [1:0] {
    OpSample  = 2'd0,
    OpPoll    = 2'd1,
    OpMarkAll = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CfgTriggerCodes   = 2'd0,
    CfgEnabledMask    = 2'd1,
    CfgHoldIntervals  = 2'd2,
    CfgReportInactive = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] trigger_codes;
    logic [7:0]  enabled_mask;
    logic [7:0]  hold_intervals;
    logic        report_inactive;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    chan_t       channel;
    logic [15:0] distance_mm;
    logic        sink_ready;
  } item_t;

  typedef struct packed {
    logic  hit;
    chan_t channel;
    logic  occupied;
  } pick_t;

endpackage
`default_nettype wire

/* sv/mohr_pick.sv */
// ---------------------------------------------------------------------------
// mohr_pick
// Priority select of the lowest pending, reportable channel.
// ---------------------------------------------------------------------------
`default_nettype none
module mohr_pick (
  input  logic [mohr_pkg::Channels-1:0] occ_i,
  input  logic [mohr_pkg::Channels-1:0] pend_i,
  input  logic                          report_inactive_i,
  output mohr_pkg::pick_t               pick_o
);
  import mohr_pkg::*;

  always_comb begin
    pick_o = '0;
    for (int i = Channels - 1; i >= 0; i--) begin
      if (pend_i[i] && (occ_i[i] || report_inactive_i)) begin
        pick_o.hit      = 1'b1;
        pick_o.channel  = 3'(i);
        pick_o.occupied = occ_i[i];
      end
    end
  end

endmodule
`default_nettype wire

/* sv/mohr_chan_state.sv */
// ---------------------------------------------------------------------------
// mohr_chan_state
// Per-channel hold counters and pending flags with their update logic.
// ---------------------------------------------------------------------------
`default_nettype none
module mohr_chan_state (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          upd_i,
  input  mohr_pkg::item_t               item_i,
  input  mohr_pkg::cfg_t                cfg_i,
  input  mohr_pkg::pick_t               pick_i,
  output logic [mohr_pkg::Channels-1:0] occ_o,
  output logic [mohr_pkg::Channels-1:0] pend_o
);
  import mohr_pkg::*;

  logic [7:0]          cnt_q [Channels];
  logic [7:0]          cnt_d [Channels];
  logic [Channels-1:0] pend_q, pend_d;

  logic [7:0]  code;
  logic [15:0] prod;
  logic [15:0] dist_eff;
  logic [16:0] dist_p1;
  logic [19:0] lhs;
  logic        det, thr_nz, en, in_range, force_occ;

  // dist < floor(prod/7)  <=>  7*(dist+1) <= prod
  always_comb begin
    code      = cfg_i.trigger_codes[{item_i.channel, 3'b000} +: 8];
    prod      = 16'(code) * 16'(code);
    dist_eff  = (item_i.distance_mm == ReadFail) ? 16'd0 : item_i.distance_mm;
    dist_p1   = {1'b0, dist_eff} + 17'd1;
    lhs       = {dist_p1, 3'b000} - {3'b000, dist_p1};
    det       = lhs <= {4'b0000, prod};
    thr_nz    = prod >= 16'(ThreshDiv);
    en        = cfg_i.enabled_mask[item_i.channel];
    in_range  = 32'(item_i.channel) < Channels;
    force_occ = en ? det : thr_nz;
  end

  always_comb begin
    for (int i = 0; i < Channels; i++) begin
      cnt_d[i]  = cnt_q[i];
      pend_d[i] = pend_q[i];
      if (upd_i) begin
        unique case (op_e'(item_i.opcode))
          OpSample: begin
            if (in_range && (item_i.channel == 3'(i))) begin
              if (force_occ) begin
                if (cnt_q[i] == 8'd0) pend_d[i] = 1'b1;
                cnt_d[i] = cfg_i.hold_intervals;
              end else if (en && (cnt_q[i] != 8'd0)) begin
                if (cnt_q[i] == 8'd1) pend_d[i] = 1'b1;
                cnt_d[i] = cnt_q[i] - 8'd1;
              end
            end
          end
          OpPoll: begin
            if (pick_i.hit && item_i.sink_ready && (pick_i.channel == 3'(i))) begin
              pend_d[i] = 1'b0;
            end
          end
          OpMarkAll: pend_d[i] = 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '{default: '0};
      pend_q <= '1;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  always_comb begin
    for (int i = 0; i < Channels; i++) begin
      occ_o[i] = cnt_q[i] != 8'd0;
    end
  end

  assign pend_o = pend_q;

endmodule
`default_nettype wire

/* sv/multichannel_occupancy_hold_reporter_unit.sv */
// ---------------------------------------------------------------------------
// multichannel_occupancy_hold_reporter_unit
// Occupancy hold counters per distance channel with a pending-report poll.
// ---------------------------------------------------------------------------
//  channel  dir  fields (lsb first)                        accepted when
//  s_*      in   tdata: channel, distance_mm, sink_ready   s_tvalid & s_tready
//                tuser: opcode
//  m_*      out  tdata: report_channel, occupied, taken    m_tvalid & m_tready
//  cfg_*    in   idx/wdata                                 cfg_we
//
// One request per cycle unless a result stalls; an accepted poll passes the
// request register, then the update logic and the priority select into the
// result register. A stalled result holds the request register; one more
// request is taken while the result waits. Reset sets all pending flags,
// clears hold counters and loads register defaults at once.
// ---------------------------------------------------------------------------
`default_nettype none
module multichannel_occupancy_hold_reporter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // channel[2:0], distance_mm[18:3], sink_ready[19]
  input  logic [1:0]  s_tuser_i,   // opcode[1:0]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,   // report_channel[2:0], report_occupied[3], report_taken[4]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);
  import mohr_pkg::*;

  cfg_t  cfg_q;
  item_t item_q;
  logic  in_vld_q;
  logic  m_vld_q;
  logic [4:0] m_data_q;
  logic  adv;
  pick_t pick;
  logic [Channels-1:0] occ, pend;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trigger_codes   <= '0;
      cfg_q.enabled_mask    <= '0;
      cfg_q.hold_intervals  <= 8'd5;
      cfg_q.report_inactive <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTriggerCodes:   cfg_q.trigger_codes   <= cfg_wdata_i;
        CfgEnabledMask:    cfg_q.enabled_mask    <= cfg_wdata_i[7:0];
        CfgHoldIntervals:  cfg_q.hold_intervals  <= cfg_wdata_i[7:0];
        CfgReportInactive: cfg_q.report_inactive <= cfg_wdata_i[0];
      endcase
    end
  end

  assign adv        = in_vld_q && (!m_vld_q || m_tready_i);
  assign s_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tready_o) begin
      in_vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      item_q.opcode      <= s_tuser_i;
      item_q.channel     <= s_tdata_i[2:0];
      item_q.distance_mm <= s_tdata_i[18:3];
      item_q.sink_ready  <= s_tdata_i[19];
    end
  end

  mohr_chan_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .pick_i (pick),
    .occ_o  (occ),
    .pend_o (pend)
  );

  mohr_pick u_pick (
    .occ_i             (occ),
    .pend_i            (pend),
    .report_inactive_i (cfg_q.report_inactive),
    .pick_o            (pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= (op_e'(item_q.opcode) == OpPoll) && pick.hit;
    end else if (m_tready_i) begin
      m_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= {item_q.sink_ready, pick.occupied, pick.channel};
    end
  end

  assign m_tvalid_o = m_vld_q;
  assign m_tdata_o  = {3'b000, m_data_q};

endmodule
`default_nettype wire

/* sv/mohr_checker.sv */
// ---------------------------------------------------------------------------
// mohr_checker
// Port-level assertions for the occupancy hold reporter, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none
`include "multichannel_occupancy_hold_reporter_unit_macros.svh"
module mohr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready_o,
  input logic        m_tvalid_o,
  input logic        m_tready_i,
  input logic [7:0]  m_tdata_o
);

  // stalled result keeps its value
  `MOHR_ASSERT(a_out_hold, m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))

  // request side only blocks behind a stalled result
  `MOHR_ASSERT(a_in_block, !s_tready_o |-> m_tvalid_o && !m_tready_i)

  // a new result needs the request stage to have moved
  `MOHR_ASSERT(a_out_rise, $rose(m_tvalid_o) |-> $past(s_tready_o))

  // no result right out of reset
  `MOHR_ASSERT_ALWAYS(a_rst_out, !rst_ni |=> !m_tvalid_o || !rst_ni)

endmodule

bind multichannel_occupancy_hold_reporter_unit mohr_checker u_mohr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_o (s_tready_o),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);
`default_nettype wire
